// ===== hw/rtl/mtmf_pkg.sv =====
`default_nettype none

package mtmf_pkg;

    // Field widths of the request and result items.
    localparam int CH_W    = 3;
    localparam int CODE_W  = 12;
    localparam int WIN_W   = 5;
    localparam int FRAC_W  = 4;
    localparam int MEAN_W  = 16;
    localparam int MV_W    = 12;
    localparam int PROD_W  = MEAN_W + MV_W;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // Default sizing of the block.
    localparam int CHANNELS_DEF   = 6;
    localparam int MAX_WINDOW_DEF = 16;

    // Window length minimum and reset value.
    localparam int               WINDOW_MIN   = 3;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd8;

    // Code full scale and the millivolt scale for a 3.3 V reference.
    localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;
    localparam logic [MV_W-1:0]   MV_FULL  = 12'd3300;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } mtmf_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multichannel_trimmed_mean_filter.sv =====
// Multichannel trimmed-mean filter for 12-bit ADC conversions.
// The slave stream carries one conversion per request, tagged with its
// channel. Each channel accumulates sum, maximum, minimum and count; when
// the count reaches the window length (cfg register, clamped to 3..MAX_WINDOW)
// the block drops the maximum and minimum, averages the rest with 4 fraction
// bits, scales that to millivolts and sends one result on the master stream.
// The channel's accumulators are then cleared. Requests for a channel at or
// above CHANNELS are taken and dropped.
// Sequencing: a request that does not close a window passes through the update
// state and back to idle. A request that closes a window goes on through the
// divide, multiply and output states before the next request is taken. The
// restoring divider has a dividend width of SUM_W + 4 (20 at the default
// sizing) and retires one quotient bit per cycle.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register, so a stalled receiver does not block
// new requests until a second result is finished and waits for the first.
// Reset (synchronous, active low) clears all channels and sets the window to 8.
`default_nettype none

module multichannel_trimmed_mean_filter #(
    parameter int CHANNELS   = mtmf_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = mtmf_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration: window_len.
    input  wire logic                               cfg_we,
    input  wire logic [mtmf_pkg::WIN_W-1:0]         cfg_wdata,
    // Requests: channel [2:0], sample [14:3], zeros above.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mtmf_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Results: out_channel [2:0], mean_code [18:3], millivolts [30:19], zeros above.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mtmf_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    import mtmf_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W    = $clog2(MAX_WINDOW * 4095 + 1);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int DIV_W    = SUM_W + FRAC_W;

    mtmf_state_t state_reg, state_next;

    logic [WIN_W-1:0]  window_len_reg;

    // Per-channel accumulators.
    logic [SUM_W-1:0]  sum_reg   [CHANNELS];
    logic [CODE_W-1:0] max_reg   [CHANNELS];
    logic [CODE_W-1:0] min_reg   [CHANNELS];
    logic [CNT_W-1:0]  count_reg [CHANNELS];

    // Latched request.
    logic [CH_W-1:0]   ch_reg;
    logic [CODE_W-1:0] sample_reg;

    logic [CH_IDX_W-1:0] ch_idx;
    logic [SUM_W-1:0]  sum_next;
    logic [CODE_W-1:0] max_next;
    logic [CODE_W-1:0] min_next;
    logic [CNT_W-1:0]  count_next;
    logic [31:0]       eff_window;
    logic              window_done;
    logic [SUM_W-1:0]  trimmed;

    logic              s_accept;
    logic              ch_ok;
    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;
    logic              out_load;

    logic [MEAN_W-1:0] mean_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [MEAN_W-1:0] out_mean_reg;
    logic [MV_W-1:0]   out_mv_reg;

    assign s_accept = s_tvalid && s_tready;
    assign ch_ok    = 32'(s_tdata[CH_W-1:0]) < CHANNELS;
    assign ch_idx   = CH_IDX_W'(ch_reg);

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            window_len_reg <= cfg_wdata;
        end
    end

    // Updated accumulators for the latched channel and the window check.
    always_comb begin
        sum_next   = sum_reg[ch_idx] + SUM_W'(sample_reg);
        max_next   = (sample_reg > max_reg[ch_idx]) ? sample_reg : max_reg[ch_idx];
        min_next   = (sample_reg < min_reg[ch_idx]) ? sample_reg : min_reg[ch_idx];
        count_next = count_reg[ch_idx] + 1'b1;

        eff_window = 32'(window_len_reg);
        if (eff_window < WINDOW_MIN) begin
            eff_window = WINDOW_MIN;
        end else if (eff_window > MAX_WINDOW) begin
            eff_window = MAX_WINDOW;
        end
        window_done = 32'(count_next) >= eff_window;
        trimmed     = sum_next - SUM_W'(max_next) - SUM_W'(min_next);
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && ch_ok) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (window_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Request latch.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg     <= s_tdata[CH_W-1:0];
            sample_reg <= s_tdata[CH_W +: CODE_W];
        end
    end

    // Accumulator write-back, or clear when the window closes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]   <= '0;
                max_reg[i]   <= '0;
                min_reg[i]   <= CODE_MAX;
                count_reg[i] <= '0;
            end
        end else if (state_reg == ST_UPDATE) begin
            if (window_done) begin
                sum_reg[ch_idx]   <= '0;
                max_reg[ch_idx]   <= '0;
                min_reg[ch_idx]   <= CODE_MAX;
                count_reg[ch_idx] <= '0;
            end else begin
                sum_reg[ch_idx]   <= sum_next;
                max_reg[ch_idx]   <= max_next;
                min_reg[ch_idx]   <= min_next;
                count_reg[ch_idx] <= count_next;
            end
        end
    end

    // Shared divider: (trimmed * 16) / (count - 2), one bit per cycle.
    mtmf_div #(
        .N_W (DIV_W),
        .D_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({trimmed, {FRAC_W{1'b0}}}),
        .divisor  (count_next - CNT_W'(2)),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Millivolt scaling: mean * 3300, the upper bits give the floor.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            mean_reg <= div_quot[MEAN_W-1:0];
            prod_reg <= div_quot[MEAN_W-1:0] * MV_FULL;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_ch_reg   <= ch_reg;
            out_mean_reg <= mean_reg;
            out_mv_reg   <= prod_reg[PROD_W-1 -: MV_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - CH_W - MEAN_W - MV_W)'(0),
                       out_mv_reg, out_mean_reg, out_ch_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/mtmf_div.sv =====
`default_nettype none

module mtmf_div #(
    parameter int N_W = 20,
    parameter int D_W = 5
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic [N_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(N_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [D_W-1:0]    rem_reg;
    logic [D_W-1:0]    dvs_reg;
    logic [N_W-1:0]    quot_reg;

    logic [D_W:0]      shifted;
    logic [D_W+1:0]    diff;
    logic              fits;
    logic [D_W-1:0]    rem_next;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        shifted  = {rem_reg, quot_reg[N_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        fits     = ~diff[D_W+1];
        rem_next = fits ? diff[D_W-1:0] : shifted[D_W-1:0];
    end

    // Step control; done pulses once the last quotient bit is in place.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            quot_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[N_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== verif/multichannel_trimmed_mean_filter_tb.sv =====
module multichannel_trimmed_mean_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtmf_pkg::*;

    localparam int NUM_CHANNELS  = CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 50;

    // One finished window: channel, trimmed mean with fraction bits, millivolts.
    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic [MEAN_W-1:0] mean;
        logic [MV_W-1:0]   mv;
    } window_mean_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [WIN_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // Request fields from bit 0 up: channel, sample, zero padding.
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // Result fields from bit 0 up: out_channel, mean_code, millivolts, zero padding.
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Predictor copy of the window register and the per-channel accumulators.
    logic [WIN_W-1:0]  window_len = WINDOW_RESET;
    logic [15:0]       acc_sum   [NUM_CHANNELS];
    logic [CODE_W-1:0] acc_max   [NUM_CHANNELS];
    logic [CODE_W-1:0] acc_min   [NUM_CHANNELS];
    logic [WIN_W-1:0]  acc_count [NUM_CHANNELS];

    window_mean_t mean_expect_q[$];
    int           mismatch_count = 0;
    bit           idle_on        = 1'b0;
    int           stall_left     = 0;

    multichannel_trimmed_mean_filter #(
        .CHANNELS   (NUM_CHANNELS),
        .MAX_WINDOW (MAX_WINDOW_DEF)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endtask

    function automatic void clear_channel(input int ch);
        acc_sum[ch]   = '0;
        acc_max[ch]   = '0;
        acc_min[ch]   = CODE_MAX;
        acc_count[ch] = '0;
    endfunction

    // Accumulate one accepted conversion and queue the mean if its window closes.
    function automatic void accumulate_conversion(input logic [CH_W-1:0] ch,
                                                  input logic [CODE_W-1:0] smp);
        int unsigned  eff;
        int unsigned  n;
        int unsigned  trimmed;
        int unsigned  mean;
        window_mean_t res;
        if (ch >= NUM_CHANNELS) begin
            return;
        end
        acc_sum[ch] = acc_sum[ch] + smp;
        if (smp > acc_max[ch]) begin
            acc_max[ch] = smp;
        end
        if (smp < acc_min[ch]) begin
            acc_min[ch] = smp;
        end
        acc_count[ch] = acc_count[ch] + 1'b1;

        // Out-of-range window settings clamp to the supported span.
        eff = window_len;
        if (eff < WINDOW_MIN) begin
            eff = WINDOW_MIN;
        end
        if (eff > MAX_WINDOW_DEF) begin
            eff = MAX_WINDOW_DEF;
        end
        n = acc_count[ch];
        if (n < eff) begin
            return;
        end

        // The divisor follows the actual count, which matters after a shortened window.
        trimmed = acc_sum[ch] - acc_max[ch] - acc_min[ch];
        mean    = (trimmed << FRAC_W) / (n - 2);
        if (mean > 32'hFFFF) begin
            mean = 32'hFFFF;
        end
        res.chan = ch;
        res.mean = mean[MEAN_W-1:0];
        res.mv   = MV_W'((mean * MV_FULL) >> MEAN_W);
        mean_expect_q.push_back(res);
        clear_channel(ch);
    endfunction

    // Send one conversion request, with an optional random gap before it.
    task automatic send_conversion(input logic [CH_W-1:0] ch, input logic [CODE_W-1:0] smp);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, smp, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accumulate_conversion(ch, smp);
    endtask

    // Drop valid, wait for every expected mean, then let the block finish any quiet request.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mean_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] len);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        window_len  = len;
    endtask

    function automatic logic [CODE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return CODE_MAX;
            end
            2: begin
                return CODE_W'($urandom_range(0, 15));
            end
            3: begin
                return CODE_MAX - CODE_W'($urandom_range(0, 15));
            end
            default: begin
                return CODE_W'($urandom);
            end
        endcase
    endfunction

    // Requests for channels past the last one must leave no trace.
    task automatic test_ignored_channels();
        send_conversion(3'd6, CODE_MAX);
        send_conversion(3'd7, '0);
    endtask

    // Smallest window (set below the minimum) with full-scale, zero and mixed samples.
    task automatic test_full_scale();
        write_window(5'd0);
        repeat (3) send_conversion(3'd0, CODE_MAX);
        repeat (3) send_conversion(3'd1, '0);
        send_conversion(3'd2, CODE_MAX);
        send_conversion(3'd2, '0);
        send_conversion(3'd2, 12'd2049);
    endtask

    // Window cut below the current count: the next sample closes it with its own divisor.
    task automatic test_window_shortened();
        write_window(5'd31);
        send_conversion(3'd3, 12'd100);
        send_conversion(3'd3, 12'd4000);
        send_conversion(3'd3, 12'd1);
        send_conversion(3'd3, 12'd2222);
        send_conversion(3'd3, 12'd3333);
        write_window(5'd4);
        send_conversion(3'd3, 12'd17);
    endtask

    // Window raised mid-collection: the channel keeps going to the new length.
    task automatic test_window_lengthened();
        write_window(5'd3);
        send_conversion(3'd4, 12'd1024);
        send_conversion(3'd4, 12'd3071);
        write_window(5'd6);
        send_conversion(3'd4, 12'd5);
        send_conversion(3'd4, 12'd4090);
        send_conversion(3'd4, 12'd2048);
        send_conversion(3'd4, 12'd777);
    endtask

    // Random conversions under one window setting; partial windows carry into the next phase.
    task automatic test_random_traffic(input logic [WIN_W-1:0] len, input int count,
                                       input bit with_idle);
        logic [CH_W-1:0] ch;
        write_window(len);
        idle_on = with_idle;
        repeat (count) begin
            if ($urandom_range(0, 9) != 0) begin
                ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            end else begin
                ch = CH_W'($urandom_range(NUM_CHANNELS, 7));
            end
            send_conversion(ch, pick_sample());
        end
    endtask

    // Random receiver back-pressure bursts, started only while idle_on is set.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected mean.
    always @(posedge aclk) begin : result_check
        window_mean_t want;
        window_mean_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[18:3], m_tdata[30:19]};
            if (mean_expect_q.size() == 0) begin
                report_mismatch("unexpected result, channel", 0, got.chan);
            end else begin
                want = mean_expect_q.pop_front();
                if (got.chan != want.chan) begin
                    report_mismatch("out_channel", want.chan, got.chan);
                end
                if (got.mean != want.mean) begin
                    report_mismatch("mean_code", want.mean, got.mean);
                end
                if (got.mv != want.mv) begin
                    report_mismatch("millivolts", want.mv, got.mv);
                end
            end
        end
    end

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            clear_channel(c);
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_ignored_channels();
        test_full_scale();
        test_window_shortened();
        test_window_lengthened();

        test_random_traffic(5'd3, 125, 1'b1);
        test_random_traffic(5'd16, 125, 1'b1);
        test_random_traffic(5'd8, 125, 1'b0);
        test_random_traffic(5'd2, 125, 1'b1);
        test_random_traffic(5'd17, 125, 1'b1);
        test_random_traffic(5'd5, 125, 1'b1);
        test_random_traffic(5'd31, 125, 1'b0);
        test_random_traffic(5'd1, 125, 1'b1);
        test_random_traffic(5'd12, 125, 1'b1);
        test_random_traffic(WIN_W'($urandom_range(0, 31)), 125, 1'b1);
        test_random_traffic(5'd10, 125, 1'b1);
        test_random_traffic(5'd4, 125, 1'b0);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
